// ----- sv/stt_pkg.sv -----
// Shared types, codes and constants of the software timer table.
`default_nettype none

package stt_pkg;

  // Default number of timer entries.
  localparam int DEF_TIMERS = 16;

  // Free-slot search examines this many entries per cycle.
  localparam int SEARCH_W   = 16;
  localparam int SEARCH_SW  = $clog2(SEARCH_W);

  // Commands carried by an input transaction.
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_POLL   = 3'd1,
    CMD_CREATE = 3'd2,
    CMD_CONFIG = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_START  = 3'd5,
    CMD_STOP   = 3'd6,
    CMD_QUERY  = 3'd7
  } cmd_t;

  // Entry state codes.
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_STOPPED = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  // Entry type codes.
  localparam logic [1:0] TY_UNDEF   = 2'd0;
  localparam logic [1:0] TY_ONESHOT = 2'd1;
  localparam logic [1:0] TY_RELOAD  = 2'd2;
  localparam logic [1:0] TY_KEEP    = 2'd3;

  // One word of the entry memory.
  typedef struct packed {
    logic [1:0]  state;
    logic [1:0]  ttype;
    logic [31:0] period;
    logic [31:0] deadline;
  } entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_EXEC
  } fsm_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic search_step;
    logic exec_go;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic in_create;
    logic search_done;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ----- sv/stt_in_if.sv -----
// Input channel of the software timer table: one command per transaction.
`default_nettype none

interface stt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  entry_id;
  logic [1:0]  entry_kind;
  logic [31:0] period;
  logic        has_handler;

  modport source (output valid, cmd, entry_id, entry_kind, period, has_handler,
                  input ready);
  modport sink (input valid, cmd, entry_id, entry_kind, period, has_handler,
                output ready);
endinterface

`default_nettype wire

// ----- sv/stt_out_if.sv -----
// Result channel of the software timer table: one result per transaction.
`default_nettype none

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [7:0]  fired_id;
  logic [31:0] fire_tick;
  logic        create_ok;
  logic [7:0]  new_id;
  logic [1:0]  state_out;
  logic [31:0] tick_now;

  modport source (output valid, fired, fired_id, fire_tick, create_ok, new_id,
                  state_out, tick_now, input ready);
  modport sink (input valid, fired, fired_id, fire_tick, create_ok, new_id,
                state_out, tick_now, output ready);
endinterface

`default_nettype wire

// ----- sv/software_timer_table.sv -----
// Software timer table: a table of TIMERS timers driven by tick, poll and management commands.
// Each command is one input transaction and produces exactly one result transaction. Tick
// advances the 32-bit system tick; poll checks the next entry in round-robin order (only
// while cfg enable is set) and reports a fired event when the tick has reached its deadline;
// create claims the first free slot; config, delete, start, stop and query act on the
// addressed entry. Entries live in a single-port-read, single-port-write memory, so every
// command is a read at acceptance followed by a modify-and-write in the execute state,
// which waits until the result register is free. Create first searches the occupancy
// map 16 entries per cycle until a free slot is found or the last chunk is checked. One
// command is worked on at a time; a finished result waits in an output register, and the
// next command is accepted while it waits. Entry occupancy is held in flip-flops cleared
// by reset, so the block is ready right after reset with no clearing pass.
`default_nettype none

module software_timer_table
  import stt_pkg::*;
#(
  parameter int TIMERS = DEF_TIMERS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  stt_in_if.sink    in_ch,
  stt_out_if.source out_ch
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  // Command sequencing.
  stt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Entry storage and execution.
  stt_dpath #(
    .TIMERS (TIMERS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ----- sv/stt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output      logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/stt_ctrl.sv -----
// Controller state machine of the software timer table.
`default_nettype none

module stt_ctrl
  import stt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ctl_sts_t sts,
  output      ctl_cmd_t ctl
);

  fsm_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (sts.in_valid) begin
          state_nxt = sts.in_create ? FSM_SEARCH : FSM_EXEC;
        end
      end
      FSM_SEARCH: begin
        if (sts.search_done) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (sts.out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Outputs toward the datapath.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      FSM_IDLE:   ctl.in_ready    = 1'b1;
      FSM_SEARCH: ctl.search_step = 1'b1;
      FSM_EXEC:   ctl.exec_go     = sts.out_free;
      default:    ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/stt_dpath.sv -----
// Datapath of the software timer table: entry memory, occupancy bits, tick and results.
`default_nettype none

module stt_dpath
  import stt_pkg::*;
#(
  parameter int TIMERS = DEF_TIMERS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata,
  stt_in_if.sink        in_ch,
  stt_out_if.source     out_ch,
  input  wire ctl_cmd_t ctl,
  output      ctl_sts_t sts
);

  localparam int IW     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int NCHUNK = (TIMERS + SEARCH_W - 1) / SEARCH_W;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PADW   = NCHUNK * SEARCH_W;
  localparam int EW     = $bits(entry_t);

  // Configuration and global state.
  logic          enable_r;
  logic [31:0]   tick_r, tick_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [(1<<IW)-1:0] vbits_r;

  // Latched command.
  cmd_t          cmd_r;
  logic [IW-1:0] addr_r;
  logic          idok_r;
  logic [1:0]    type_r;
  logic [31:0]   period_r;
  logic          hnd_r;

  // Free-slot search.
  logic [CW-1:0] chunk_r;
  logic          found_r;
  logic [IW-1:0] slot_r;
  logic [PADW-1:0] free_pad;
  logic [SEARCH_W-1:0] chunk_bits;
  logic          hit;
  logic [SEARCH_SW-1:0] hit_pos;
  logic [CW+SEARCH_SW-1:0] slot_full;
  logic          last_chunk;

  // Memory access.
  logic          accept;
  logic          exec;
  logic [IW-1:0] raddr;
  logic          ram_we;
  logic [IW-1:0] waddr;
  entry_t        wword;
  entry_t        cur;
  logic [EW-1:0] rdata;
  logic          vbit;
  logic          live;
  logic          vset, vclr;
  logic [31:0]   sum_start, sum_reload, sum_create;

  // Next result.
  logic          fired_nxt;
  logic [7:0]    fired_id_nxt;
  logic [31:0]   fire_tick_nxt;
  logic          create_ok_nxt;
  logic [7:0]    new_id_nxt;
  logic [1:0]    state_out_nxt;

  // Result register.
  logic          out_valid_r;
  logic          fired_r;
  logic [7:0]    fired_id_r;
  logic [31:0]   fire_tick_r;
  logic          create_ok_r;
  logic [7:0]    new_id_r;
  logic [1:0]    state_out_r;
  logic [31:0]   tick_now_r;

  assign accept = in_ch.valid & ctl.in_ready;
  assign exec   = ctl.exec_go;
  assign in_ch.ready = ctl.in_ready;

  // Status toward the controller.
  assign sts.in_valid    = in_ch.valid;
  assign sts.in_create   = (cmd_t'(in_ch.cmd) == CMD_CREATE);
  assign sts.search_done = hit | last_chunk;
  assign sts.out_free    = ~out_valid_r | out_ch.ready;

  // The entry is read while the transaction is accepted.
  assign raddr = (cmd_t'(in_ch.cmd) == CMD_POLL) ? scan_r : in_ch.entry_id[IW-1:0];

  stt_ram #(
    .WIDTH (EW),
    .DEPTH (TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wword),
    .re    (accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cur  = entry_t'(rdata);
  assign vbit = vbits_r[addr_r];
  assign live = idok_r & vbit;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      enable_r <= cfg_wdata;
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd_t'(in_ch.cmd);
      addr_r   <= raddr;
      idok_r   <= ({1'b0, in_ch.entry_id} < 9'(TIMERS));
      type_r   <= in_ch.entry_kind;
      period_r <= in_ch.period;
      hnd_r    <= in_ch.has_handler;
    end
  end

  // Free map, padded with occupied entries past the table end.
  always_comb begin
    free_pad = '0;
    for (int i = 0; i < TIMERS; i++) begin
      free_pad[i] = ~vbits_r[i];
    end
  end

  // Priority encoder over one chunk of the free map.
  always_comb begin
    chunk_bits = free_pad[int'(chunk_r) * SEARCH_W +: SEARCH_W];
    hit        = 1'b0;
    hit_pos    = '0;
    for (int i = SEARCH_W - 1; i >= 0; i--) begin
      if (chunk_bits[i]) begin
        hit     = 1'b1;
        hit_pos = SEARCH_SW'(i);
      end
    end
  end

  assign slot_full  = {chunk_r, hit_pos};
  assign last_chunk = (chunk_r == CW'(NCHUNK - 1));

  // Search progress; the chunk index stops at the last chunk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
      found_r <= 1'b0;
    end else if (accept) begin
      chunk_r <= '0;
      found_r <= 1'b0;
    end else if (ctl.search_step) begin
      if (!last_chunk) begin
        chunk_r <= chunk_r + 1'b1;
      end
      if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.search_step && hit) begin
      slot_r <= slot_full[IW-1:0];
    end
  end

  assign sum_start  = tick_r + cur.period;
  assign sum_reload = cur.deadline + cur.period;
  assign sum_create = tick_r + period_r;

  // Command execution: read-modify-write of one entry and the result.
  always_comb begin
    ram_we        = 1'b0;
    waddr         = addr_r;
    wword         = cur;
    vset          = 1'b0;
    vclr          = 1'b0;
    tick_nxt      = tick_r;
    scan_nxt      = scan_r;
    fired_nxt     = 1'b0;
    fired_id_nxt  = '0;
    fire_tick_nxt = '0;
    create_ok_nxt = 1'b0;
    new_id_nxt    = '0;
    state_out_nxt = ST_EMPTY;
    if (exec) begin
      unique case (cmd_r)
        CMD_TICK: begin
          tick_nxt = tick_r + 32'd1;
        end
        CMD_POLL: begin
          if (enable_r) begin
            if (vbit && cur.state == ST_RUNNING && tick_r >= cur.deadline) begin
              fired_nxt     = 1'b1;
              fired_id_nxt  = 8'(addr_r);
              fire_tick_nxt = tick_r;
              ram_we        = 1'b1;
              if (cur.ttype == TY_ONESHOT) begin
                wword.state = ST_STOPPED;
              end else if (cur.ttype == TY_RELOAD) begin
                wword.deadline = sum_reload;
              end else begin
                wword.state = ST_ERROR;
              end
            end
            scan_nxt = (scan_r == IW'(TIMERS - 1)) ? '0 : scan_r + 1'b1;
          end
        end
        CMD_CREATE: begin
          if (found_r && hnd_r && type_r != TY_KEEP && period_r != 32'd0) begin
            ram_we         = 1'b1;
            waddr          = slot_r;
            wword.state    = ST_RUNNING;
            wword.ttype    = type_r;
            wword.period   = period_r;
            wword.deadline = sum_create;
            vset           = 1'b1;
            create_ok_nxt  = 1'b1;
            new_id_nxt     = 8'(slot_r);
          end
        end
        CMD_CONFIG: begin
          if (live) begin
            ram_we = 1'b1;
            if (type_r != TY_KEEP) begin
              wword.ttype = type_r;
            end
            if (period_r != 32'd0) begin
              wword.period = period_r;
            end
          end
        end
        CMD_DELETE: begin
          vclr = idok_r;
        end
        CMD_START: begin
          if (live) begin
            ram_we         = 1'b1;
            wword.deadline = sum_start;
            wword.state    = ST_RUNNING;
          end
        end
        CMD_STOP: begin
          if (live) begin
            ram_we      = 1'b1;
            wword.state = ST_STOPPED;
          end
        end
        CMD_QUERY: begin
          state_out_nxt = !idok_r ? ST_ERROR : (vbit ? cur.state : ST_EMPTY);
        end
        default: ;
      endcase
    end
  end

  // Tick, scan index and occupancy bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      scan_r  <= '0;
      vbits_r <= '0;
    end else begin
      tick_r <= tick_nxt;
      scan_r <= scan_nxt;
      if (vset) begin
        vbits_r[waddr] <= 1'b1;
      end else if (vclr) begin
        vbits_r[addr_r] <= 1'b0;
      end
    end
  end

  // Result register: loaded at execution, released when the transaction is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      fired_r     <= fired_nxt;
      fired_id_r  <= fired_id_nxt;
      fire_tick_r <= fire_tick_nxt;
      create_ok_r <= create_ok_nxt;
      new_id_r    <= new_id_nxt;
      state_out_r <= state_out_nxt;
      tick_now_r  <= tick_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.fired     = fired_r;
  assign out_ch.fired_id  = fired_id_r;
  assign out_ch.fire_tick = fire_tick_r;
  assign out_ch.create_ok = create_ok_r;
  assign out_ch.new_id    = new_id_r;
  assign out_ch.state_out = state_out_r;
  assign out_ch.tick_now  = tick_now_r;

  // A deleted entry reads as empty from the next cycle on.
  a_delete_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && cmd_r == CMD_DELETE && idok_r) |=> !vbits_r[$past(addr_r)])
    else $error("deleted entry still marked occupied");

  // A create only ever claims a slot that is free.
  a_create_free: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && create_ok_nxt) |-> !vbits_r[slot_r])
    else $error("create claimed an occupied slot");

  // Every enabled poll moves the scan index one place, wrapping at the table end.
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && cmd_r == CMD_POLL && enable_r) |=>
      (scan_r == (($past(scan_r) == IW'(TIMERS - 1)) ? '0 : $past(scan_r) + 1'b1)))
    else $error("scan index did not advance");

  // Execution never overwrites a result that has not been taken.
  a_exec_slot: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> (!out_valid_r || out_ch.ready))
    else $error("result overwritten before transaction completed");

endmodule

`default_nettype wire
